FILE: design/sha2c_pkg.sv
// shared types, constants and functions for the sha-256/sha-224 compression core
// round constants, initial hash values, sigma functions and control structs
// no dependencies
package sha2c_pkg;

  localparam int WORD_W      = 32;
  localparam int NUM_VARS    = 8;
  localparam int SCHED_DEPTH = 16;
  localparam int SCHED_AW    = $clog2(SCHED_DEPTH);
  localparam int NUM_ROUNDS  = 64;
  localparam int ROUND_W     = $clog2(NUM_ROUNDS);
  localparam int DIG_IDX_W   = $clog2(NUM_VARS);

  // last digest word index for each mode
  localparam logic [DIG_IDX_W-1:0] LAST_IDX_256 = DIG_IDX_W'(NUM_VARS - 1);
  localparam logic [DIG_IDX_W-1:0] LAST_IDX_224 = DIG_IDX_W'(NUM_VARS - 2);

  typedef logic [WORD_W-1:0]                word_t;
  typedef logic [NUM_VARS-1:0][WORD_W-1:0]  hash_t;
  typedef logic [SCHED_AW-1:0]              sched_addr_t;
  typedef logic [ROUND_W-1:0]               round_idx_t;

  // input beat payload
  typedef struct packed {
    word_t msg_word;
    logic  first_block;
    logic  last_block;
  } in_beat_t;

  // output beat payload
  typedef struct packed {
    word_t digest_word;
    logic  digest_end;
  } out_beat_t;

  // control from the sequencer to the message schedule
  typedef struct packed {
    logic        ld_en;
    sched_addr_t ld_addr;
    logic        rd_en;
    round_idx_t  rd_round;
    logic        rnd_en;
    round_idx_t  cur_round;
  } sched_ctrl_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       init;
    logic       step;
    round_idx_t idx;
  } round_ctrl_t;

  localparam hash_t IV_256 = {
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
  };

  localparam hash_t IV_224 = {
    32'hBEFA4FA4, 32'h64F98FA7, 32'h68581511, 32'hFFC00B31,
    32'hF70E5939, 32'h3070DD17, 32'h367CD507, 32'hC1059ED8
  };

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // round constant table
  function automatic word_t k_const(input round_idx_t t);
    case (t)
      6'd0:  k_const = 32'h428A2F98;  6'd1:  k_const = 32'h71374491;
      6'd2:  k_const = 32'hB5C0FBCF;  6'd3:  k_const = 32'hE9B5DBA5;
      6'd4:  k_const = 32'h3956C25B;  6'd5:  k_const = 32'h59F111F1;
      6'd6:  k_const = 32'h923F82A4;  6'd7:  k_const = 32'hAB1C5ED5;
      6'd8:  k_const = 32'hD807AA98;  6'd9:  k_const = 32'h12835B01;
      6'd10: k_const = 32'h243185BE;  6'd11: k_const = 32'h550C7DC3;
      6'd12: k_const = 32'h72BE5D74;  6'd13: k_const = 32'h80DEB1FE;
      6'd14: k_const = 32'h9BDC06A7;  6'd15: k_const = 32'hC19BF174;
      6'd16: k_const = 32'hE49B69C1;  6'd17: k_const = 32'hEFBE4786;
      6'd18: k_const = 32'h0FC19DC6;  6'd19: k_const = 32'h240CA1CC;
      6'd20: k_const = 32'h2DE92C6F;  6'd21: k_const = 32'h4A7484AA;
      6'd22: k_const = 32'h5CB0A9DC;  6'd23: k_const = 32'h76F988DA;
      6'd24: k_const = 32'h983E5152;  6'd25: k_const = 32'hA831C66D;
      6'd26: k_const = 32'hB00327C8;  6'd27: k_const = 32'hBF597FC7;
      6'd28: k_const = 32'hC6E00BF3;  6'd29: k_const = 32'hD5A79147;
      6'd30: k_const = 32'h06CA6351;  6'd31: k_const = 32'h14292967;
      6'd32: k_const = 32'h27B70A85;  6'd33: k_const = 32'h2E1B2138;
      6'd34: k_const = 32'h4D2C6DFC;  6'd35: k_const = 32'h53380D13;
      6'd36: k_const = 32'h650A7354;  6'd37: k_const = 32'h766A0ABB;
      6'd38: k_const = 32'h81C2C92E;  6'd39: k_const = 32'h92722C85;
      6'd40: k_const = 32'hA2BFE8A1;  6'd41: k_const = 32'hA81A664B;
      6'd42: k_const = 32'hC24B8B70;  6'd43: k_const = 32'hC76C51A3;
      6'd44: k_const = 32'hD192E819;  6'd45: k_const = 32'hD6990624;
      6'd46: k_const = 32'hF40E3585;  6'd47: k_const = 32'h106AA070;
      6'd48: k_const = 32'h19A4C116;  6'd49: k_const = 32'h1E376C08;
      6'd50: k_const = 32'h2748774C;  6'd51: k_const = 32'h34B0BCB5;
      6'd52: k_const = 32'h391C0CB3;  6'd53: k_const = 32'h4ED8AA4A;
      6'd54: k_const = 32'h5B9CCA4F;  6'd55: k_const = 32'h682E6FF3;
      6'd56: k_const = 32'h748F82EE;  6'd57: k_const = 32'h78A5636F;
      6'd58: k_const = 32'h84C87814;  6'd59: k_const = 32'h8CC70208;
      6'd60: k_const = 32'h90BEFFFA;  6'd61: k_const = 32'hA4506CEB;
      6'd62: k_const = 32'hBEF9A3F7;  6'd63: k_const = 32'hC67178F2;
      default: k_const = '0;
    endcase
  endfunction

endpackage

FILE: design/sha2c_sched_ram.sv
// sixteen-word schedule memory: one write port, two registered read ports
// depends on sha2c_pkg
module sha2c_sched_ram (
  input  logic                  clk,
  input  logic                  we,
  input  sha2c_pkg::sched_addr_t waddr,
  input  sha2c_pkg::word_t      wdata,
  input  logic                  re,
  input  sha2c_pkg::sched_addr_t raddr_a,
  input  sha2c_pkg::sched_addr_t raddr_b,
  output sha2c_pkg::word_t      rdata_a,
  output sha2c_pkg::word_t      rdata_b
);
  import sha2c_pkg::*;

  word_t mem [SCHED_DEPTH];
  word_t rdata_a_r;
  word_t rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered and enabled by re
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

FILE: design/sha2c_msg_sched.sv
// message schedule: two mirrored schedule memories give four reads per round
// expands the rolling sixteen-word window in place; depends on sha2c_pkg, sha2c_sched_ram
module sha2c_msg_sched (
  input  logic                   clk,
  input  sha2c_pkg::sched_ctrl_t ctrl,
  input  sha2c_pkg::word_t       ld_word,
  output sha2c_pkg::word_t       w_out
);
  import sha2c_pkg::*;

  sched_addr_t rd_base;
  sched_addr_t addr_t16;
  sched_addr_t addr_t15;
  sched_addr_t addr_t2;
  sched_addr_t addr_t7;
  word_t       w_t16;
  word_t       w_t15;
  word_t       w_t2;
  word_t       w_t7;
  word_t       w_exp;
  logic        exp_en;
  logic        we;
  sched_addr_t waddr;
  word_t       wdata;

  // prefetch addresses for the next round, modulo the window depth
  assign rd_base  = ctrl.rd_round[SCHED_AW-1:0];
  assign addr_t16 = rd_base;
  assign addr_t15 = rd_base + SCHED_AW'(1);
  assign addr_t2  = rd_base - SCHED_AW'(2);
  assign addr_t7  = rd_base - SCHED_AW'(7);

  // expansion: the word written this round is never read by the next prefetch
  assign w_exp  = small_s1(w_t2) + w_t7 + small_s0(w_t15) + w_t16;
  assign exp_en = ctrl.rnd_en && (ctrl.cur_round >= ROUND_W'(SCHED_DEPTH));
  assign w_out  = exp_en ? w_exp : w_t16;

  // write port shared by message load and expansion
  assign we    = ctrl.ld_en || exp_en;
  assign waddr = ctrl.ld_en ? ctrl.ld_addr : ctrl.cur_round[SCHED_AW-1:0];
  assign wdata = ctrl.ld_en ? ld_word : w_exp;

  sha2c_sched_ram u_bank_a (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (ctrl.rd_en),
    .raddr_a (addr_t16),
    .raddr_b (addr_t15),
    .rdata_a (w_t16),
    .rdata_b (w_t15)
  );

  sha2c_sched_ram u_bank_b (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (ctrl.rd_en),
    .raddr_a (addr_t2),
    .raddr_b (addr_t7),
    .rdata_a (w_t2),
    .rdata_b (w_t7)
  );

endmodule

FILE: design/sha2c_round.sv
// round datapath: working variables a..h and one compression round per cycle
// depends on sha2c_pkg
module sha2c_round (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha2c_pkg::round_ctrl_t ctrl,
  input  sha2c_pkg::hash_t       chain_in,
  input  sha2c_pkg::word_t       w_in,
  output sha2c_pkg::hash_t       vars_out
);
  import sha2c_pkg::*;

  hash_t vars_r;
  hash_t vars_nxt;
  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  // round function
  always_comb begin
    ch  = (vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]);
    maj = (vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]);
    t1  = vars_r[7] + big_s1(vars_r[4]) + ch + k_const(ctrl.idx) + w_in;
    t2  = big_s0(vars_r[0]) + maj;
    vars_nxt = vars_r;
    if (ctrl.init) begin
      vars_nxt = chain_in;
    end else if (ctrl.step) begin
      vars_nxt[7] = vars_r[6];
      vars_nxt[6] = vars_r[5];
      vars_nxt[5] = vars_r[4];
      vars_nxt[4] = vars_r[3] + t1;
      vars_nxt[3] = vars_r[2];
      vars_nxt[2] = vars_r[1];
      vars_nxt[1] = vars_r[0];
      vars_nxt[0] = t1 + t2;
    end
  end

  // working variable registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vars_r <= '0;
    end else begin
      vars_r <= vars_nxt;
    end
  end

  assign vars_out = vars_r;

endmodule

FILE: design/sha256_block_compression_core.sv
// SHA-256 / SHA-224 block compression core, top level: sequencer, chaining value, digest output.
// Message words are loaded at one beat per cycle while input is taken, sixteen to a block. The
// sixteenth beat starts compression: a setup state, 64 round steps and a
// state that adds into the chaining value. The round loop runs one round
// per cycle, fed by four schedule reads from two mirrored memories with
// registered read ports. Input is not taken during compression or while
// digest words are being loaded into the output register. After a last
// block the digest follows as eight beats (seven in SHA-224 mode), most
// significant word first. The mode register selects the initial value when
// a first block reloads it and the digest length at emission; it should be
// written only while the core is idle.
// Depends on sha2c_pkg, sha2c_msg_sched, sha2c_round.
module sha256_block_compression_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha2c_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sha2c_pkg::out_beat_t out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);
  import sha2c_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PREP,
    S_ROUND,
    S_ADD,
    S_EMIT
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  logic [SCHED_AW-1:0]    word_cnt_r;
  logic [SCHED_AW-1:0]    word_cnt_nxt;
  round_idx_t             round_cnt_r;
  round_idx_t             round_cnt_nxt;
  logic [DIG_IDX_W-1:0]   emit_idx_r;
  logic [DIG_IDX_W-1:0]   emit_idx_nxt;
  logic                   last_r;
  logic                   last_nxt;
  logic                   trunc_r;
  hash_t                  chain_r;
  hash_t                  chain_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_beat_t              out_data_r;
  out_beat_t              out_data_nxt;
  logic                   in_fire;
  logic                   out_slot;
  logic [DIG_IDX_W-1:0]   last_idx;
  sched_ctrl_t            sched_ctrl;
  round_ctrl_t            round_ctrl;
  word_t                  w_cur;
  hash_t                  vars;

  assign in_ready = (state_r == S_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_slot = !out_valid_r || out_ready;
  assign last_idx = trunc_r ? LAST_IDX_224 : LAST_IDX_256;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunc_r <= 1'b0;
    end else if (cfg_wr_en) begin
      trunc_r <= cfg_wr_data;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    word_cnt_nxt  = word_cnt_r;
    round_cnt_nxt = round_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    last_nxt      = last_r;
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    sched_ctrl.ld_en     = 1'b0;
    sched_ctrl.ld_addr   = word_cnt_r;
    sched_ctrl.rd_en     = 1'b0;
    sched_ctrl.rd_round  = round_cnt_r + ROUND_W'(1);
    sched_ctrl.rnd_en    = 1'b0;
    sched_ctrl.cur_round = round_cnt_r;

    round_ctrl.init = 1'b0;
    round_ctrl.step = 1'b0;
    round_ctrl.idx  = round_cnt_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          sched_ctrl.ld_en = 1'b1;
          word_cnt_nxt     = word_cnt_r + SCHED_AW'(1);
          if (word_cnt_r == SCHED_AW'(SCHED_DEPTH - 1)) begin
            last_nxt = in_data.last_block;
            if (in_data.first_block) begin
              chain_nxt = trunc_r ? IV_224 : IV_256;
            end
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        // prefetch round 0 operands, seed working variables
        sched_ctrl.rd_en    = 1'b1;
        sched_ctrl.rd_round = '0;
        round_ctrl.init     = 1'b1;
        round_cnt_nxt       = '0;
        state_nxt           = S_ROUND;
      end
      S_ROUND: begin
        sched_ctrl.rd_en  = 1'b1;
        sched_ctrl.rnd_en = 1'b1;
        round_ctrl.step   = 1'b1;
        round_cnt_nxt     = round_cnt_r + ROUND_W'(1);
        if (round_cnt_r == ROUND_W'(NUM_ROUNDS - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < NUM_VARS; i++) begin
          chain_nxt[i] = chain_r[i] + vars[i];
        end
        emit_idx_nxt = '0;
        state_nxt    = last_r ? S_EMIT : S_LOAD;
      end
      S_EMIT: begin
        if (out_slot) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.digest_word = chain_r[emit_idx_r];
          out_data_nxt.digest_end  = (emit_idx_r == last_idx);
          emit_idx_nxt             = emit_idx_r + DIG_IDX_W'(1);
          if (emit_idx_r == last_idx) begin
            state_nxt = S_LOAD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      word_cnt_r  <= '0;
      round_cnt_r <= '0;
      emit_idx_r  <= '0;
      last_r      <= 1'b0;
      chain_r     <= IV_256;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_cnt_r  <= word_cnt_nxt;
      round_cnt_r <= round_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      last_r      <= last_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  sha2c_msg_sched u_msg_sched (
    .clk     (clk),
    .ctrl    (sched_ctrl),
    .ld_word (in_data.msg_word),
    .w_out   (w_cur)
  );

  sha2c_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (round_ctrl),
    .chain_in (chain_r),
    .w_in     (w_cur),
    .vars_out (vars)
  );

endmodule

FILE: verif/tb_sha256_block_compression_core.sv
// self-checking testbench for sha256_block_compression_core: message blocks in, digest beats out
// a behavioral sha-256/sha-224 model predicts all digest words but "abc"'s; checked in order
// depends on sha2c_pkg and the core rtl
module tb_sha256_block_compression_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sha2c_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  // drain time covers compression after the sixteenth word, plus digest unload
  localparam int DRAIN_CYCLES = 120;

  // sha-256 round constants, index 0 first
  localparam logic [0:63][31:0] ROUND_K = {
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [0:7][31:0] INIT_256 = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [0:7][31:0] INIT_224 = {
    32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
    32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
  };

  // padded "abc" block: {msg_word, first_block, last_block}
  // flags on the first fifteen words are noise, no first_block on the final word
  localparam logic [0:15][33:0] ABC_ROWS = {
    {32'h61626380, 1'b1, 1'b0}, {32'h00000000, 1'b0, 1'b1},
    {32'h00000000, 1'b1, 1'b1}, {32'h00000000, 1'b0, 1'b0},
    {32'h00000000, 1'b1, 1'b0}, {32'h00000000, 1'b0, 1'b1},
    {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b1, 1'b1},
    {32'h00000000, 1'b0, 1'b0}, {32'h00000000, 1'b1, 1'b0},
    {32'h00000000, 1'b0, 1'b1}, {32'h00000000, 1'b0, 1'b0},
    {32'h00000000, 1'b1, 1'b1}, {32'h00000000, 1'b0, 1'b0},
    {32'h00000000, 1'b1, 1'b0}, {32'h00000018, 1'b0, 1'b1}
  };

  // published sha-256 digest of "abc"
  localparam logic [0:7][31:0] ABC_DIGEST = {
    32'hBA7816BF, 32'h8F01CFEA, 32'h414140DE, 32'h5DAE2223,
    32'hB00361A3, 32'h96177A9C, 32'hB410FF61, 32'hF20015AD
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  // hash model state
  word_t     chain_q [8];
  word_t     sched_q [16];
  logic [3:0] word_idx;
  logic      mode_224;
  logic      hold_digest;
  out_beat_t digest_q [$];

  int        err_count = 0;
  int        cycle_count = 0;
  int        in_idle_pct;
  int        out_idle_pct;
  out_beat_t want_beat;

  sha256_block_compression_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic word_t ror32(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic void load_init();
    for (int i = 0; i < 8; i++) begin
      chain_q[i] = mode_224 ? INIT_224[i] : INIT_256[i];
    end
  endfunction

  // 64 rounds over the rolling schedule window, then add into the chain
  function automatic void compress_block();
    word_t v [8];
    word_t w;
    word_t t1;
    word_t t2;
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched_q[t];
      end else begin
        w = ssig1(sched_q[(t - 2) & 15]) + sched_q[(t - 7) & 15]
          + ssig0(sched_q[(t - 15) & 15]) + sched_q[t & 15];
        sched_q[t & 15] = w;
      end
      t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
      t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endfunction

  // one accepted message word into the hash model
  function automatic void absorb_word(input in_beat_t beat);
    int n;
    out_beat_t d;
    sched_q[word_idx] = beat.msg_word;
    if (word_idx != 4'd15) begin
      word_idx = word_idx + 4'd1;
      return;
    end
    word_idx = 4'd0;
    if (beat.first_block) load_init();
    compress_block();
    if (!beat.last_block || hold_digest) return;
    n = mode_224 ? 7 : 8;
    for (int k = 0; k < n; k++) begin
      d.digest_word = chain_q[k];
      d.digest_end  = (k == n - 1);
      digest_q.push_back(d);
    end
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // input beat, with random idle cycles before it
  task automatic send_word(input in_beat_t beat);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_word(beat);
    @(negedge clk);
  endtask

  // wait until all digests are out and the core has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    mode_224 = m;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // random messages of one to three blocks, with mode changes between blocks
  task automatic run_messages(input int num_blocks);
    int sent;
    int nblk;
    in_beat_t beat;
    sent = 0;
    while (sent < num_blocks) begin
      nblk = $urandom_range(1, 3);
      if ($urandom_range(2) == 0) begin
        settle();
        write_mode(1'($urandom_range(1)));
      end
      for (int b = 0; b < nblk; b++) begin
        if (b != 0 && $urandom_range(5) == 0) begin
          settle();
          write_mode(1'($urandom_range(1)));
        end
        for (int i = 0; i < 15; i++) begin
          beat.msg_word    = rand_word();
          beat.first_block = 1'($urandom_range(1));
          beat.last_block  = 1'($urandom_range(1));
          send_word(beat);
        end
        // final word carries the flags that count, sometimes broken
        beat.msg_word    = rand_word();
        beat.first_block = (b == 0) ? ($urandom_range(7) != 0) : ($urandom_range(11) == 0);
        beat.last_block  = (b == nblk - 1) ? ($urandom_range(9) != 0)
                                           : ($urandom_range(9) == 0);
        send_word(beat);
        sent++;
      end
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // digest beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest beat", out_data.digest_word, 32'h0);
      end else begin
        want_beat = digest_q.pop_front();
        if (out_data.digest_word !== want_beat.digest_word)
          report_mismatch("digest_word", out_data.digest_word, want_beat.digest_word);
        if (out_data.digest_end !== want_beat.digest_end)
          report_mismatch("digest_end", 32'(out_data.digest_end), 32'(want_beat.digest_end));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sha256_block_compression_core verification failed");
      $finish;
    end
  end

  // main sequence
  initial begin
    out_beat_t abc_beat;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_idle_pct  = 7;
    out_idle_pct = 76;
    hold_digest  = 1'b0;
    mode_224     = 1'b0;
    word_idx     = 4'd0;
    load_init();
    for (int i = 0; i < 16; i++) sched_q[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_mode(1'b0);

    // known "abc" digest, chaining straight from reset
    for (int k = 0; k < 8; k++) begin
      abc_beat.digest_word = ABC_DIGEST[k];
      abc_beat.digest_end  = (k == 7);
      digest_q.push_back(abc_beat);
    end
    hold_digest = 1'b1;
    for (int i = 0; i < 16; i++) send_word(in_beat_t'(ABC_ROWS[i]));
    hold_digest = 1'b0;

    // sender mostly busy, receiver mostly stalled
    settle();
    write_mode(1'b1);
    run_messages(6);

    // sender mostly idle, receiver mostly ready
    settle();
    in_idle_pct  = 76;
    out_idle_pct = 7;
    write_mode(1'b0);
    run_messages(6);

    // back to back
    settle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_mode(1'b1);
    run_messages(7);

    settle();
    if (err_count == 0) begin
      $display("sha256_block_compression_core verification clean");
    end else begin
      $display("sha256_block_compression_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sha2c_pkg.sv
design/sha2c_sched_ram.sv
design/sha2c_msg_sched.sv
design/sha2c_round.sv
design/sha256_block_compression_core.sv
verif/tb_sha256_block_compression_core.sv
